// ===== hdl/nsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_pkg: shared types and constants for the NMEA sentence framer
// Holds the phase encoding, the result record, the framing characters and
// the nibble-to-hex helper used by the checksum compare.
// ----------------------------------------------------------------------------
package nsf_pkg;

    // Framing characters
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;

    // Fixed widths of the result fields
    localparam int KEEP_W = 9;

    // Framer phase
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_BODY = 2'd1,
        PH_STAR = 2'd2,
        PH_CS1  = 2'd3
    } phase_t;

    // Width-independent part of the framer state
    typedef struct packed {
        phase_t     phase;
        logic [7:0] run_xor;
        logic [7:0] first_char;
    } frame_state_t;

    // One result item
    typedef struct packed {
        logic              kept;
        logic [KEEP_W-1:0] index;
        logic              done;
        logic              good;
        logic [KEEP_W-1:0] length;
    } result_t;

    // Upper-case ASCII hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'hA)
        begin
            hex_char = wide + 8'h30;
        end
        else
        begin
            hex_char = wide - 8'h0A + 8'h41;
        end
    endfunction

endpackage

// ===== hdl/nsf_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_step: next-state and result logic of the sentence framer
// Takes one byte and the current state and gives the state after the byte
// and the result item it produces. Purely combinational.
// ----------------------------------------------------------------------------
module nsf_step
    import nsf_pkg::*;
#(
    parameter int CNT_W = 9,
    parameter int LIMIT = 507
)
(
    input  logic [7:0]       rx_byte,
    input  frame_state_t     state,
    input  logic [CNT_W-1:0] count,
    output frame_state_t     state_next,
    output logic [CNT_W-1:0] count_next,
    output result_t          result
);

    logic [CNT_W-1:0] count_inc;
    logic             at_limit;
    logic             sum_match;

    assign count_inc = count + CNT_W'(1);
    assign at_limit  = (count >= CNT_W'(LIMIT));
    assign sum_match = (hex_char(state.run_xor[7:4]) == state.first_char) &&
                       (hex_char(state.run_xor[3:0]) == rx_byte);

    // Advance the framer by one byte
    always_comb
    begin
        state_next    = state;
        count_next    = count;
        result.kept   = 1'b0;
        result.index  = '0;
        result.done   = 1'b0;
        result.good   = 1'b0;
        result.length = '0;

        unique case (state.phase)
            PH_HUNT:
            begin
                if (rx_byte == CHAR_DOLLAR)
                begin
                    state_next.phase   = PH_BODY;
                    state_next.run_xor = '0;
                    result.kept        = 1'b1;
                    count_next         = CNT_W'(1);
                end
            end
            PH_BODY:
            begin
                if (rx_byte == CHAR_DOLLAR)
                begin
                    // restart the sentence at position zero
                    state_next.run_xor = '0;
                    result.kept        = 1'b1;
                    count_next         = CNT_W'(1);
                end
                else if (at_limit)
                begin
                    // drop an overlong sentence
                    state_next.phase   = PH_HUNT;
                    state_next.run_xor = '0;
                    count_next         = '0;
                end
                else
                begin
                    result.kept  = 1'b1;
                    result.index = KEEP_W'(count);
                    count_next   = count_inc;
                    if (rx_byte == CHAR_STAR)
                    begin
                        state_next.phase = PH_STAR;
                    end
                    else
                    begin
                        state_next.run_xor = state.run_xor ^ rx_byte;
                    end
                end
            end
            PH_STAR:
            begin
                result.kept           = 1'b1;
                result.index          = KEEP_W'(count);
                count_next            = count_inc;
                state_next.first_char = rx_byte;
                state_next.phase      = PH_CS1;
            end
            PH_CS1:
            begin
                result.kept  = 1'b1;
                result.index = KEEP_W'(count);
                result.done  = 1'b1;
                if (sum_match)
                begin
                    result.good   = 1'b1;
                    result.length = KEEP_W'(count_inc);
                end
                state_next.phase   = PH_HUNT;
                state_next.run_xor = '0;
                count_next         = '0;
            end
            default:
            begin
                state_next.phase = PH_HUNT;
            end
        endcase
    end

endmodule

// ===== hdl/nsf_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_out_stage: result register of the sentence framer
// Holds one result item until the output takes it and frees itself in the
// same cycle, so a new item can load every cycle while items are taken.
// ----------------------------------------------------------------------------
module nsf_out_stage
    import nsf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    output logic    free,
    output logic    valid,
    input  logic    taken,
    output result_t result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free       = !valid_reg || taken;
    assign valid      = valid_reg;
    assign result_out = data_reg;

    // Track occupancy of the result register
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

// ===== hdl/nmea_sentence_framer_top.sv =====
`timescale 1ns / 1ps
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one byte per cycle; the input is ready whenever the result
// register is empty or is being taken in the same cycle.
// Reset: asynchronous, active low; the framer returns to hunting for '$'
// with count, XOR and checksum character cleared and no result pending.
// ----------------------------------------------------------------------------
// nmea_sentence_framer_top: byte-serial NMEA 0183 sentence framer
// Frames '$' ... '*' hh sentences, reports each kept byte with its buffer
// position and checks the two hex checksum characters against the body XOR.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_top
    import nsf_pkg::*;
#(
    parameter int BUFFER_BYTES = 512
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                byte_kept,
    output logic [KEEP_W-1:0]   keep_index,
    output logic                frame_done,
    output logic                frame_good,
    output logic [KEEP_W-1:0]   frame_length
);

    localparam int CNT_W = $clog2(BUFFER_BYTES);
    localparam int LIMIT = BUFFER_BYTES - 5;

    frame_state_t     state_reg;
    frame_state_t     state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    result_t          step_result;
    result_t          out_result;
    logic             out_free;
    logic             in_fire;

    assign in_ready = out_free;
    assign in_fire  = in_valid && in_ready;

    // Next state and result for the presented byte
    nsf_step #(
        .CNT_W (CNT_W),
        .LIMIT (LIMIT)
    ) u_step (
        .rx_byte    (rx_byte),
        .state      (state_reg),
        .count      (count_reg),
        .state_next (state_next),
        .count_next (count_next),
        .result     (step_result)
    );

    // Advance the framer state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_HUNT;
            state_reg.run_xor    <= '0;
            state_reg.first_char <= '0;
            count_reg            <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Hold the result until the output transfer
    nsf_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_fire),
        .result_in  (step_result),
        .free       (out_free),
        .valid      (out_valid),
        .taken      (out_ready),
        .result_out (out_result)
    );

    assign byte_kept    = out_result.kept;
    assign keep_index   = out_result.index;
    assign frame_done   = out_result.done;
    assign frame_good   = out_result.good;
    assign frame_length = out_result.length;

`ifndef NO_ASSERTIONS
    // A good frame is always a finished frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_good |-> frame_done)
    else $error("frame_good without frame_done");

    // Length is reported only for a good frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_good |-> frame_length == '0)
    else $error("frame_length set on a frame that is not good");

    // A dropped byte carries no position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_kept |-> keep_index == '0)
    else $error("keep_index set on a byte that was not kept");

    // The second checksum character ends the sentence
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && state_reg.phase == PH_CS1 |=>
            state_reg.phase == PH_HUNT && count_reg == '0 && out_valid && frame_done)
    else $error("framer did not return to hunting after the checksum");

    // The byte count never passes the buffer bound
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIMIT + 2))
    else $error("byte count beyond buffer bound");
`endif

endmodule
